FILE: rtl/core/image_transpose_rotate90_defines.svh
// ---------------------------------------------------------------------------
// Image transpose / rotate engine: assertion macros
// Shorthand for the concurrent checks on the engine's ports.
// ---------------------------------------------------------------------------
`ifndef IMAGE_TRANSPOSE_ROTATE90_DEFINES_SVH
`define IMAGE_TRANSPOSE_ROTATE90_DEFINES_SVH

// Check that is switched off while reset is high.
`define IMGTR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that also covers the reset cycles themselves.
`define IMGTR_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/core/imgtr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Image transpose / rotate engine: shared package
// Beat types, register indexes, reset values and controller types.
// ---------------------------------------------------------------------------
package imgtr_pkg;

   localparam int MAX_DIM_DEFAULT = 256;
   localparam int PIX_W           = 24;
   localparam int CFG_W           = 9;
   localparam int CSR_IDX_W       = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_ROTATE_MODE  = 2'd2,
      CSR_COLOR_IMAGE  = 2'd3
   } csr_index_type;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(256);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(256);
   localparam logic             ROTATE_RESET = 1'b0;
   localparam logic             COLOR_RESET  = 1'b1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       last_of_frame;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_FETCH
   } ctrl_state_type;

   typedef struct packed {
      logic load_en;  // write the incoming pixel, advance the load position
      logic read_en;  // issue a store read, advance the output position
      logic capture;  // store read data is valid: register the result beat
   } ctrl_cmd_type;

endpackage

FILE: rtl/core/imgtr_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module imgtr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/imgtr_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Image transpose / rotate engine: controller
// Accepts commands, sequences store writes, reads and result beats.
// ---------------------------------------------------------------------------
module imgtr_ctrl
   import imgtr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         operation,
   output logic         busy,
   output ctrl_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           accept;

   assign accept = start && (state_ff != ST_INIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // A read moves to FETCH for the cycle in which the store data arrives.
   always_comb begin
      unique case (state_ff)
         ST_INIT: begin
            state_in = ST_IDLE;
         end
         ST_IDLE, ST_FETCH: begin
            if (accept && operation == OP_READ) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      busy        = (state_ff == ST_INIT);
      cmd.load_en = accept && (operation == OP_LOAD);
      cmd.read_en = accept && (operation == OP_READ);
      cmd.capture = (state_ff == ST_FETCH);
   end

endmodule

FILE: rtl/core/imgtr_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Image transpose / rotate engine: datapath
// Configuration registers, position counters, pixel store and result register.
// ---------------------------------------------------------------------------
module imgtr_datapath
   import imgtr_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   input  req_type              req_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data
);

   localparam int CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DIM_W  = CNT_W + 1;
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] DIM_A = ADDR_W'(MAX_DIM);
   localparam logic [DIM_W-1:0]  DIM_MAX = DIM_W'(MAX_DIM);

   // Configuration registers.
   logic [CFG_W-1:0] width_ff, height_ff;
   logic             rotate_ff, color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         rotate_ff <= ROTATE_RESET;
         color_ff  <= COLOR_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            CSR_ROTATE_MODE:  rotate_ff <= csr_wdata[0];
            CSR_COLOR_IMAGE:  color_ff  <= csr_wdata[0];
         endcase
      end
   end

   // Effective sizes: zero acts as one, anything above MAX_DIM as MAX_DIM.
   logic [DIM_W-1:0] w_eff, h_eff;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (32'(width_ff) > 32'(MAX_DIM)) begin
         w_eff = DIM_MAX;
      end else begin
         w_eff = DIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (32'(height_ff) > 32'(MAX_DIM)) begin
         h_eff = DIM_MAX;
      end else begin
         h_eff = DIM_W'(height_ff);
      end
   end

   // Load position, raster order over the input image.
   logic [CNT_W-1:0] load_row_ff, load_col_ff, load_row_in, load_col_in;
   logic [CNT_W-1:0] lrow, lcol;
   logic [DIM_W-1:0] lcol_p1, lrow_p1;
   logic [ADDR_W-1:0] wr_addr;

   always_comb begin
      lrow    = (DIM_W'(load_row_ff) >= h_eff) ? '0 : load_row_ff;
      lcol    = (DIM_W'(load_col_ff) >= w_eff) ? '0 : load_col_ff;
      lcol_p1 = DIM_W'(lcol) + DIM_W'(1);
      lrow_p1 = DIM_W'(lrow) + DIM_W'(1);
      if (lcol_p1 >= w_eff) begin
         load_col_in = '0;
         load_row_in = (lrow_p1 >= h_eff) ? '0 : lrow_p1[CNT_W-1:0];
      end else begin
         load_col_in = lcol_p1[CNT_W-1:0];
         load_row_in = lrow;
      end
      wr_addr = ADDR_W'(lrow) * DIM_A + ADDR_W'(lcol);
   end

   // Output position: the output image is h_eff wide and w_eff tall.
   logic [CNT_W-1:0] emit_row_ff, emit_col_ff, emit_row_in, emit_col_in;
   logic [CNT_W-1:0] erow, ecol, src_row;
   logic [DIM_W-1:0] ecol_p1, erow_p1, flip_row;
   logic [ADDR_W-1:0] rd_addr;
   logic              last_hit;

   always_comb begin
      erow     = (DIM_W'(emit_row_ff) >= w_eff) ? '0 : emit_row_ff;
      ecol     = (DIM_W'(emit_col_ff) >= h_eff) ? '0 : emit_col_ff;
      flip_row = h_eff - DIM_W'(1) - DIM_W'(ecol);
      src_row  = rotate_ff ? flip_row[CNT_W-1:0] : ecol;
      rd_addr  = ADDR_W'(src_row) * DIM_A + ADDR_W'(erow);
      last_hit = (DIM_W'(erow) == w_eff - DIM_W'(1)) &&
                 (DIM_W'(ecol) == h_eff - DIM_W'(1));
      ecol_p1  = DIM_W'(ecol) + DIM_W'(1);
      erow_p1  = DIM_W'(erow) + DIM_W'(1);
      if (ecol_p1 >= h_eff) begin
         emit_col_in = '0;
         emit_row_in = (erow_p1 >= w_eff) ? '0 : erow_p1[CNT_W-1:0];
      end else begin
         emit_col_in = ecol_p1[CNT_W-1:0];
         emit_row_in = erow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_row_ff <= '0;
         load_col_ff <= '0;
         emit_row_ff <= '0;
         emit_col_ff <= '0;
      end else begin
         if (cmd.load_en) begin
            load_row_ff <= load_row_in;
            load_col_ff <= load_col_in;
         end
         if (cmd.read_en) begin
            emit_row_ff <= emit_row_in;
            emit_col_ff <= emit_col_in;
         end
      end
   end

   // Pixel store.
   logic [PIX_W-1:0] rd_pix;

   imgtr_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.load_en),
      .wr_addr (wr_addr),
      .wr_data ({req_data.in_red, req_data.in_green, req_data.in_blue}),
      .rd_en   (cmd.read_en),
      .rd_addr (rd_addr),
      .rd_data (rd_pix)
   );

   // Side information that travels with the store read.
   logic last_ff, last_in;
   logic gray_ff, gray_in;

   assign last_in = last_hit;
   assign gray_in = !color_ff;

   always_ff @(posedge clock) begin
      if (cmd.read_en) begin
         last_ff <= last_in;
         gray_ff <= gray_in;
      end
   end

   // Result register.
   rsp_type rsp_ff, rsp_in;
   logic    strobe_ff, strobe_in;

   always_comb begin
      rsp_in.out_red       = rd_pix[23:16];
      rsp_in.out_green     = gray_ff ? 8'd0 : rd_pix[15:8];
      rsp_in.out_blue      = gray_ff ? 8'd0 : rd_pix[7:0];
      rsp_in.last_of_frame = last_ff;
      strobe_in            = cmd.capture;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      if (cmd.capture) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

FILE: rtl/core/image_transpose_rotate90.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Image transpose / rotate engine: top level
// Frame buffer that returns its image transposed or turned a quarter clockwise.
// ---------------------------------------------------------------------------
// Usage:
// A command beat is taken on a rising edge where start is high and busy is
// low. A load beat (operation = 0) writes the next input pixel in raster
// order, top row first, and produces no result. A read beat (operation = 1)
// returns the next pixel of the output image in raster order; the output is
// image_height wide and image_width tall, and last_of_frame marks its final
// pixel. Both positions wrap at the end of the frame.
// The engine takes one beat every clock cycle while busy is low: each beat is
// one access to the pixel store, which has separate write and read ports. A
// read beat's result shows on rsp_data with rsp_strobe high once it has passed
// the registered store read and the result register, and results come in the
// order of the read beats.
// The receiver cannot stall: every result is valid for one cycle only.
// Reset clears the positions and the configuration registers to their
// defaults and drops any result in flight; busy is high for the first cycle
// after reset. The store is not cleared, so read a frame only after it has
// been loaded in full. Write the csr_ registers only while no beat is in
// flight.
// ---------------------------------------------------------------------------
module image_transpose_rotate90
   import imgtr_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   // Commands from the controller to the datapath.
   ctrl_cmd_type cmd;

   // The controller decides when a beat is taken and when a result is due.
   imgtr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_data.operation),
      .busy      (busy),
      .cmd       (cmd)
   );

   // The datapath holds the configuration, the two raster positions, the
   // pixel store and the result register.
   imgtr_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: rtl/core/imgtr_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Image transpose / rotate engine: port checker
// Checks reset behaviour, busy and the timing of result beats against the command beats.
// ---------------------------------------------------------------------------
`include "image_transpose_rotate90_defines.svh"

module imgtr_checker
   import imgtr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe
);

   logic read_taken;

   assign read_taken = start && !busy && (req_data.operation == OP_READ);

   `IMGTR_ASSERT_RST(a_reset_quiet, reset |=> (busy && !rsp_strobe), "result or ready after reset")
   `IMGTR_ASSERT(a_read_answered, read_taken |=> ##1 rsp_strobe, "read beat not answered")
   `IMGTR_ASSERT(a_no_spurious, rsp_strobe |-> $past(read_taken, 2), "result without read beat")
   `IMGTR_ASSERT(a_busy_once, busy |=> !busy, "busy longer than one cycle")

endmodule

bind image_transpose_rotate90 imgtr_checker u_imgtr_checker (.*);

FILE: tb/image_transpose_rotate90_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Image transpose / rotate engine: self-checking testbench
// Loads frames pixel by pixel, reads them back transposed or rotated, and
// compares every result beat with a behavioral frame buffer kept alongside.
// ---------------------------------------------------------------------------
module image_transpose_rotate90_test;
   import imgtr_pkg::*;

   localparam int DIM           = MAX_DIM_DEFAULT;
   // Beat count at which the random part stops. The directed part is 612 beats.
   localparam int TOTAL_BEATS   = 820;
   // Settling wait after the last result, before touching the registers.
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 300000;

   // The scoreboard owns a behavioral copy of the engine: the pixel store, the
   // load and output positions and the four registers. Each accepted beat is
   // run through it, and every read beat leaves one expected pixel behind.
   class frame_scoreboard;
      bit [PIX_W-1:0]   pixel_mem [DIM*DIM];
      bit               pixel_loaded [DIM*DIM];
      logic [CFG_W-1:0] width_reg;
      logic [CFG_W-1:0] height_reg;
      logic             rotate_reg;
      logic             color_reg;
      int unsigned      load_row, load_col, emit_row, emit_col;
      rsp_type          pending_pixels[$];
      int unsigned      errors, load_beats, read_beats, pixels_checked;

      function new();
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         rotate_reg = ROTATE_RESET;
         color_reg  = COLOR_RESET;
      endfunction

      // A size of zero behaves as one, anything past the store as the store.
      static function int unsigned clamp_dim(logic [CFG_W-1:0] v);
         if (v == 0) return 1;
         if (v > DIM) return DIM;
         return 32'(v);
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function void set_reg(csr_index_type idx, logic [CFG_W-1:0] val);
         case (idx)
            CSR_IMAGE_WIDTH:  width_reg  = val;
            CSR_IMAGE_HEIGHT: height_reg = val;
            CSR_ROTATE_MODE:  rotate_reg = val[0];
            CSR_COLOR_IMAGE:  color_reg  = val[0];
            default: ;
         endcase
      endfunction

      // Store address that the next read beat will fetch. The output image is
      // height wide and width tall, so the output row picks the input column.
      function int unsigned read_source();
         int unsigned w, h, row, col, src_row;
         w = clamp_dim(width_reg);
         h = clamp_dim(height_reg);
         row = (emit_row >= w) ? 0 : emit_row;
         col = (emit_col >= h) ? 0 : emit_col;
         src_row = rotate_reg ? (h - 1 - col) : col;
         return src_row * DIM + row;
      endfunction

      function void take_beat(req_type beat);
         int unsigned w, h, slot;
         bit [PIX_W-1:0] pix;
         rsp_type want;
         w = clamp_dim(width_reg);
         h = clamp_dim(height_reg);
         if (beat.operation == OP_LOAD) begin
            // Positions left beyond a shrunken frame restart at zero.
            if (load_row >= h) load_row = 0;
            if (load_col >= w) load_col = 0;
            slot = load_row * DIM + load_col;
            pixel_mem[slot]    = {beat.in_red, beat.in_green, beat.in_blue};
            pixel_loaded[slot] = 1'b1;
            load_beats++;
            load_col++;
            if (load_col >= w) begin
               load_col = 0;
               load_row++;
               if (load_row >= h) load_row = 0;
            end
         end else begin
            if (emit_row >= w) emit_row = 0;
            if (emit_col >= h) emit_col = 0;
            pix = pixel_mem[read_source()];
            // Grey frames keep only the first channel; the others read as zero.
            want.out_red       = pix[23:16];
            want.out_green     = color_reg ? pix[15:8] : 8'h00;
            want.out_blue      = color_reg ? pix[7:0] : 8'h00;
            want.last_of_frame = (emit_row == w - 1) && (emit_col == h - 1);
            pending_pixels.push_back(want);
            read_beats++;
            emit_col++;
            if (emit_col >= h) begin
               emit_col = 0;
               emit_row++;
               if (emit_row >= w) emit_row = 0;
            end
         end
      endfunction

      task check_pixel(rsp_type got);
         rsp_type want;
         if (pending_pixels.size() == 0) begin
            report($sformatf("result beat %h with no read beat waiting", got));
            return;
         end
         want = pending_pixels.pop_front();
         pixels_checked++;
         if (got.out_red !== want.out_red)
            report($sformatf("pixel %0d out_red %h, want %h",
                             pixels_checked, got.out_red, want.out_red));
         if (got.out_green !== want.out_green)
            report($sformatf("pixel %0d out_green %h, want %h",
                             pixels_checked, got.out_green, want.out_green));
         if (got.out_blue !== want.out_blue)
            report($sformatf("pixel %0d out_blue %h, want %h",
                             pixels_checked, got.out_blue, want.out_blue));
         if (got.last_of_frame !== want.last_of_frame)
            report($sformatf("pixel %0d last_of_frame %b, want %b",
                             pixels_checked, got.last_of_frame, want.last_of_frame));
      endtask
   endclass

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   logic                 busy;
   req_type              req_data  = '0;
   logic                 rsp_strobe;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   frame_scoreboard sb = new();
   int unsigned     cycle_count = 0;
   int unsigned     settings_used = 0;

   image_transpose_rotate90 dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result beats last one cycle and cannot be held off, so they are taken
   // at every edge where the strobe is high. Values read here are those that
   // the edge itself sampled.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) sb.check_pixel(rsp_data);
   end

   // Watchdog: the slowest correct run is far below this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         sb.report($sformatf("timeout with %0d result beats still outstanding",
                             sb.pending_pixels.size()));
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic req_type pixel_beat(logic op, logic [PIX_W-1:0] rgb);
      return req_type'({op, rgb});
   endfunction

   // Offer one beat and hold it until the engine takes it. Before each beat the
   // sender keeps idling with a chance of 37 percent per draw for the first third
   // of the run, of 79 percent for the second, and not at all for the rest. Start
   // stays high between beats that follow each other without a gap.
   task automatic send_beat(req_type beat);
      int unsigned idle_pct;
      int unsigned sent;
      sent = sb.load_beats + sb.read_beats;
      idle_pct = (sent < TOTAL_BEATS / 3) ? 37 : (sent < 2 * TOTAL_BEATS / 3) ? 79 : 0;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.take_beat(beat);
   endtask

   // Writes all four registers on consecutive edges. Only called while the
   // engine has nothing in flight.
   task automatic program_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                                logic [CFG_W-1:0] rot, logic [CFG_W-1:0] color);
      logic [CFG_W-1:0] vals [4];
      csr_index_type    idx;
      vals = '{w, h, rot, color};
      idx  = CSR_IMAGE_WIDTH;
      csr_we <= 1'b1;
      repeat (4) begin
         csr_index <= idx;
         csr_wdata <= vals[idx];
         @(posedge clock);
         sb.set_reg(idx, vals[idx]);
         idx = idx.next();
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Loads produce nothing, so after the last result a settling wait follows
   // to let any trailing store write finish before the registers change.
   task automatic drain_results();
      start <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One setting of the registers: optionally a whole frame of loads first,
   // then a mix weighted toward reads. A read whose source pixel was never
   // loaded is turned into a load, since such a read is not allowed.
   task automatic run_phase(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                            logic [CFG_W-1:0] rot, logic [CFG_W-1:0] color,
                            bit preload, int unsigned extra);
      int unsigned frame_pixels;
      bit          want_read;
      program_frame(w, h, rot, color);
      if (preload) begin
         frame_pixels = frame_scoreboard::clamp_dim(w) * frame_scoreboard::clamp_dim(h);
         repeat (frame_pixels) send_beat(pixel_beat(OP_LOAD, PIX_W'($urandom)));
      end
      repeat (extra) begin
         want_read = ($urandom_range(0, 99) < 75);
         if (want_read && sb.pixel_loaded[sb.read_source()])
            send_beat(pixel_beat(OP_READ, PIX_W'($urandom)));
         else
            send_beat(pixel_beat(OP_LOAD, PIX_W'($urandom)));
      end
      drain_results();
   endtask

   initial begin
      logic [PIX_W-1:0] corner_pixels [6];
      logic [CFG_W-1:0] w_word, h_word;
      int unsigned      pick;

      corner_pixels = '{24'hFF00FF, 24'h00FF00, 24'hAA55A5,
                        24'h5AA55A, 24'h000000, 24'hFFFFFF};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // Directed: a 2 wide, 3 tall color frame with all-zero and all-one
      // channels, read back transposed. The read beats carry junk in their
      // pixel fields, which must be ignored.
      program_frame(9'd2, 9'd3, 9'd0, 9'd1);
      foreach (corner_pixels[i]) send_beat(pixel_beat(OP_LOAD, corner_pixels[i]));
      repeat (6) send_beat(pixel_beat(OP_READ, 24'hFFFFFF));
      drain_results();

      // Same store, now rotated and grey: green and blue must come out zero.
      // The output position has wrapped to the frame start.
      program_frame(9'd2, 9'd3, 9'd1, 9'd0);
      repeat (6) send_beat(pixel_beat(OP_READ, 24'h000000));
      drain_results();

      // Zero sizes behave as a one-pixel frame: every read is the last one.
      program_frame(9'd0, 9'd0, 9'd1, 9'd1);
      send_beat(pixel_beat(OP_LOAD, 24'h123456));
      send_beat(pixel_beat(OP_READ, 24'hA5A5A5));
      drain_results();

      // Largest frames in each direction, with junk in the upper bits of the
      // mode registers; the oversized height behaves as the full store size.
      run_phase(9'd256, 9'd1, 9'h1FF, 9'h0FE, 1'b1, 40);
      run_phase(9'd1, 9'd511, 9'h100, 9'h1FF, 1'b1, 40);

      // Random settings, mostly small frames so that frames wrap often and
      // positions get left mid-frame when the size changes. Now and then a
      // frame is not reloaded, so reads hit whatever the store still holds.
      while (sb.load_beats + sb.read_beats < TOTAL_BEATS) begin
         pick   = $urandom_range(0, 15);
         w_word = CFG_W'($urandom_range(1, 8));
         h_word = CFG_W'($urandom_range(1, 8));
         if (pick == 0) begin
            w_word = $urandom_range(0, 1) ? 9'd256 : CFG_W'($urandom_range(257, 511));
            h_word = CFG_W'($urandom_range(0, 1));
         end else if (pick == 1) begin
            h_word = CFG_W'($urandom_range(256, 511));
            w_word = CFG_W'($urandom_range(0, 1));
         end else if (pick == 2) begin
            w_word = '0;
         end else if (pick == 3) begin
            h_word = '0;
         end
         run_phase(w_word, h_word, CFG_W'($urandom), CFG_W'($urandom),
                   $urandom_range(0, 3) != 0, $urandom_range(10, 60));
      end

      drain_results();
      $display("Covered %0d load beats and %0d read beats (%0d checked) over %0d settings,",
               sb.load_beats, sb.read_beats, sb.pixels_checked, settings_used);
      $display("transpose and rotate, color and grey, sizes from one pixel to full store.");
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
